// File: sv/psq_pkg.sv
// Package: table geometry, slot entry layout and result status codes.
package psq_pkg;

  localparam int SLOTS  = 32;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] time_val;
    logic [7:0]  prio;
    logic        ends;
    logic        rem;
  } slot_t;

  typedef enum logic [1:0] {
    ST_ENTRY  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

endpackage

// File: sv/psq_slot_ram.sv
// Slot table memory: one write port, one registered read port, write-first on collision.
module psq_slot_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [psq_pkg::ADDR_W-1:0] waddr_i,
  input  psq_pkg::slot_t             wdata_i,
  input  logic                       re_i,
  input  logic [psq_pkg::ADDR_W-1:0] raddr_i,
  output psq_pkg::slot_t             rdata_o
);
  import psq_pkg::*;

  slot_t mem [SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/psq_key_cmp.sv
// Ordering key compare: priority first, then remainder class after head class.
module psq_key_cmp (
  input  logic [7:0] a_prio_i,
  input  logic       a_rem_i,
  input  logic [7:0] b_prio_i,
  input  logic       b_rem_i,
  output logic       gt_o
);
  import psq_pkg::*;

  assign gt_o = {a_prio_i, a_rem_i} > {b_prio_i, b_rem_i};

endmodule

// File: sv/priority_schedule_queue_with_quantum.sv
// Top level: sorted schedule table with quantum split, insert and drain sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  command  | start_i / busy_o       | mode_i, exec_time_i, prio_i
//  result   | done_o (strobe)        | status_o, proc_id_o, slice_time_o, slice_prio_o,
//           |                        | ends_process_o, last_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_data_i (time quantum)
//
//  Insert: the command is accepted, then each piece is compared from the top entry down,
//  each larger entry is shifted up one slot, and the piece is written into the gap.
//  A rejected insert or a drain of an empty table is answered straight from idle. A drain
//  reads the table once per result. Reset clears count and id and sets the quantum to 4;
//  table contents are left as is. Results are strobed for one cycle and cannot be stalled.
module priority_schedule_queue_with_quantum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [15:0] exec_time_i,
  input  logic [7:0]  prio_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  proc_id_o,
  output logic [15:0] slice_time_o,
  output logic [7:0]  slice_prio_o,
  output logic        ends_process_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import psq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_PUT   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [7:0]       next_id_q, next_id_d;
  logic [15:0]      quantum_q;
  slot_t            piece_q, piece_d;
  logic             second_q, second_d;
  logic [15:0]      rtime_q, rtime_d;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  slot_t             wdata, rdata;
  logic              gt, piece_done;
  logic [CNT_W-1:0]  idx_m1, idx_m2, idx_p1, count_m1, count_p1;
  logic [CNT_W:0]    need_sum;
  logic              split;

  logic        out_load;
  status_e     out_status;
  logic [7:0]  out_id;
  logic [15:0] out_time;
  logic [7:0]  out_prio;
  logic        out_ends, out_last;

  logic        done_q;
  status_e     status_q;
  logic [7:0]  proc_id_q;
  logic [15:0] slice_time_q;
  logic [7:0]  slice_prio_q;
  logic        ends_q, last_q;

  psq_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  psq_key_cmp u_cmp (
    .a_prio_i (rdata.prio),
    .a_rem_i  (rdata.rem),
    .b_prio_i (piece_q.prio),
    .b_rem_i  (piece_q.rem),
    .gt_o     (gt)
  );

  assign idx_m1   = idx_q - CNT_W'(1);
  assign idx_m2   = idx_q - CNT_W'(2);
  assign idx_p1   = idx_q + CNT_W'(1);
  assign count_m1 = count_q - CNT_W'(1);
  assign count_p1 = count_q + CNT_W'(1);
  assign split    = exec_time_i > quantum_q;
  assign need_sum = {1'b0, count_q} + (split ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    next_id_d  = next_id_q;
    piece_d    = piece_q;
    second_d   = second_q;
    rtime_d    = rtime_q;
    we         = 1'b0;
    waddr      = idx_q[ADDR_W-1:0];
    wdata      = piece_q;
    re         = 1'b0;
    raddr      = '0;
    piece_done = 1'b0;
    out_load   = 1'b0;
    out_status = ST_ENTRY;
    out_id     = '0;
    out_time   = '0;
    out_prio   = '0;
    out_ends   = 1'b0;
    out_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i) begin
            if (count_q == '0) begin
              out_load   = 1'b1;
              out_status = ST_EMPTY;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              idx_d   = '0;
              state_d = S_DRAIN;
            end
          end else if (need_sum > (CNT_W+1)'(SLOTS)) begin
            out_load   = 1'b1;
            out_status = ST_FULL;
          end else begin
            piece_d.id       = next_id_q;
            piece_d.time_val = split ? quantum_q : exec_time_i;
            piece_d.prio     = prio_i;
            piece_d.ends     = ~split;
            piece_d.rem      = 1'b0;
            second_d         = split;
            rtime_d          = exec_time_i - quantum_q;
            idx_d            = count_q;
            if (count_q != '0) begin
              re      = 1'b1;
              raddr   = count_m1[ADDR_W-1:0];
              state_d = S_CMP;
            end else begin
              state_d = S_PUT;
            end
          end
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (gt) begin
          wdata = rdata;
          idx_d = idx_m1;
          if (idx_m1 == '0) begin
            state_d = S_PUT;
          end else begin
            re    = 1'b1;
            raddr = idx_m2[ADDR_W-1:0];
          end
        end else begin
          piece_done = 1'b1;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        piece_done = 1'b1;
      end
      S_DRAIN: begin
        out_load   = 1'b1;
        out_status = ST_ENTRY;
        out_id     = rdata.id;
        out_time   = rdata.time_val;
        out_prio   = rdata.prio;
        out_ends   = rdata.ends;
        out_last   = (idx_p1 == count_q);
        if (idx_p1 == count_q) begin
          count_d = '0;
          state_d = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = idx_p1[ADDR_W-1:0];
          idx_d = idx_p1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (piece_done) begin
      count_d = count_p1;
      if (second_q) begin
        piece_d.time_val = rtime_q;
        piece_d.ends     = 1'b1;
        piece_d.rem      = 1'b1;
        second_d         = 1'b0;
        re               = 1'b1;
        raddr            = count_q[ADDR_W-1:0];
        idx_d            = count_p1;
        state_d          = S_CMP;
      end else begin
        out_load   = 1'b1;
        out_status = ST_ACCEPT;
        out_id     = next_id_q;
        next_id_d  = next_id_q + 8'd1;
        state_d    = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      next_id_q <= '0;
      quantum_q <= 16'd4;
      second_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      second_q  <= second_d;
      done_q    <= out_load;
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    piece_q <= piece_d;
    rtime_q <= rtime_d;
    if (out_load) begin
      status_q     <= out_status;
      proc_id_q    <= out_id;
      slice_time_q <= out_time;
      slice_prio_q <= out_prio;
      ends_q       <= out_ends;
      last_q       <= out_last;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign proc_id_o      = proc_id_q;
  assign slice_time_o   = slice_time_q;
  assign slice_prio_o   = slice_prio_q;
  assign ends_process_o = ends_q;
  assign last_o         = last_q;

endmodule

// File: sv/psq_checker.sv
// Port-level checker for the schedule queue, bound to the top level.
module psq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [7:0]  proc_id_o,
  input logic [15:0] slice_time_o,
  input logic        ends_process_o,
  input logic        last_o
);
  import psq_pkg::*;

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy_o)
    else $error("non-final beat while block idle");

  a_cmd_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || (done_o && last_o))
    else $error("accepted command neither started nor answered");

  a_busy_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o && last_o)
    else $error("busy dropped without a final beat");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_ENTRY) |-> last_o && (slice_time_o == '0) && !ends_process_o)
    else $error("status beat is not a lone final beat");

  a_reject_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((status_o == ST_FULL) || (status_o == ST_EMPTY)) |-> (proc_id_o == '0))
    else $error("reject or empty beat carries an id");

endmodule

bind priority_schedule_queue_with_quantum psq_checker u_psq_checker (.*);

// File: verif/testbench.sv
// Testbench for the priority schedule queue: directed table, random phases, self-checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psq_pkg::*;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   DRAIN_WAIT  = 40;

  typedef struct packed {
    status_e     status;
    logic [7:0]  proc_id;
    logic [15:0] slice_time;
    logic [7:0]  slice_prio;
    logic        ends;
    logic        last;
  } sched_result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] exec_time;
    logic [7:0]  prio;
    logic        typed;
    status_e     st;
    logic [7:0]  id;
  } cmd_row_t;

  localparam cmd_row_t DIRECTED_ROWS [23] = '{
    '{MODE_DRAIN,  16'd0,     8'd0,   1'b1, ST_EMPTY,  8'd0},
    '{MODE_INSERT, 16'd0,     8'd0,   1'b1, ST_ACCEPT, 8'd0},
    '{MODE_INSERT, 16'd4,     8'd255, 1'b1, ST_ACCEPT, 8'd1},
    '{MODE_INSERT, 16'd5,     8'd255, 1'b1, ST_ACCEPT, 8'd2},
    '{MODE_INSERT, 16'd65535, 8'd0,   1'b1, ST_ACCEPT, 8'd3},
    '{MODE_INSERT, 16'd3,     8'd0,   1'b1, ST_ACCEPT, 8'd4},
    '{MODE_INSERT, 16'd65535, 8'd255, 1'b1, ST_ACCEPT, 8'd5},
    '{MODE_INSERT, 16'd9,     8'd0,   1'b1, ST_ACCEPT, 8'd6},
    '{MODE_INSERT, 16'd100,   8'd128, 1'b1, ST_ACCEPT, 8'd7},
    '{MODE_INSERT, 16'd5,     8'd0,   1'b1, ST_ACCEPT, 8'd8},
    '{MODE_INSERT, 16'd32768, 8'd1,   1'b1, ST_ACCEPT, 8'd9},
    '{MODE_INSERT, 16'd7,     8'd128, 1'b1, ST_ACCEPT, 8'd10},
    '{MODE_INSERT, 16'd21845, 8'd85,  1'b1, ST_ACCEPT, 8'd11},
    '{MODE_INSERT, 16'd43690, 8'd170, 1'b1, ST_ACCEPT, 8'd12},
    '{MODE_INSERT, 16'd6,     8'd255, 1'b1, ST_ACCEPT, 8'd13},
    '{MODE_INSERT, 16'd65535, 8'd0,   1'b1, ST_ACCEPT, 8'd14},
    '{MODE_INSERT, 16'd12,    8'd3,   1'b1, ST_ACCEPT, 8'd15},
    '{MODE_INSERT, 16'd255,   8'd1,   1'b1, ST_ACCEPT, 8'd16},
    '{MODE_INSERT, 16'd9,     8'd0,   1'b1, ST_FULL,   8'd0},
    '{MODE_INSERT, 16'd1,     8'd128, 1'b1, ST_ACCEPT, 8'd17},
    '{MODE_INSERT, 16'd0,     8'd0,   1'b1, ST_FULL,   8'd0},
    '{MODE_DRAIN,  16'd65535, 8'd255, 1'b0, ST_ENTRY,  8'd0},
    '{MODE_DRAIN,  16'd0,     8'd0,   1'b1, ST_EMPTY,  8'd0}
  };

  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 72;
  localparam int          IDLE_PCT [PHASES] = '{0, 60, 0, 13};
  localparam logic [15:0] QUANTA   [PHASES] = '{16'd0, 16'd65535, 16'd9, 16'd1000};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic        mode_i         = 1'b0;
  logic [15:0] exec_time_i    = '0;
  logic [7:0]  prio_i         = '0;
  logic        cfg_valid_i    = 1'b0;
  logic [15:0] cfg_data_i     = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  proc_id_o;
  logic [15:0] slice_time_o;
  logic [7:0]  slice_prio_o;
  logic        ends_process_o;
  logic        last_o;
  logic        cfg_ready_o;

  slot_t         sched_table [$];
  logic [7:0]    next_proc_id = '0;
  logic [15:0]   quantum_reg  = 16'd4;
  sched_result_t pending_results [$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   cycle_cnt    = 0;

  priority_schedule_queue_with_quantum u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .exec_time_i    (exec_time_i),
    .prio_i         (prio_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .proc_id_o      (proc_id_o),
    .slice_time_o   (slice_time_o),
    .slice_prio_o   (slice_prio_o),
    .ends_process_o (ends_process_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic void add_expected(sched_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void place_piece(slot_t piece);
    int pos;
    pos = 0;
    while (pos < sched_table.size() &&
           {sched_table[pos].prio, sched_table[pos].rem} <= {piece.prio, piece.rem}) begin
      pos++;
    end
    sched_table.insert(pos, piece);
  endfunction

  function automatic void schedule_command(logic mode, logic [15:0] et, logic [7:0] pr,
                                           bit keep);
    sched_result_t r;
    slot_t         piece;
    bit            split;
    int            need;
    int            n;
    r = '0;
    r.last = 1'b1;
    if (mode == MODE_DRAIN) begin
      n = sched_table.size();
      if (n == 0) begin
        r.status = ST_EMPTY;
        if (keep) add_expected(r);
      end else begin
        for (int i = 0; i < n; i++) begin
          r.status     = ST_ENTRY;
          r.proc_id    = sched_table[i].id;
          r.slice_time = sched_table[i].time_val;
          r.slice_prio = sched_table[i].prio;
          r.ends       = sched_table[i].ends;
          r.last       = (i == n - 1);
          if (keep) add_expected(r);
        end
        sched_table.delete();
      end
    end else begin
      split = et > quantum_reg;
      need  = split ? 2 : 1;
      if (sched_table.size() + need > SLOTS) begin
        r.status = ST_FULL;
      end else begin
        piece.id   = next_proc_id;
        piece.prio = pr;
        if (split) begin
          piece.time_val = quantum_reg;
          piece.ends     = 1'b0;
          piece.rem      = 1'b0;
          place_piece(piece);
          piece.time_val = et - quantum_reg;
          piece.ends     = 1'b1;
          piece.rem      = 1'b1;
          place_piece(piece);
        end else begin
          piece.time_val = et;
          piece.ends     = 1'b1;
          piece.rem      = 1'b0;
          place_piece(piece);
        end
        r.status  = ST_ACCEPT;
        r.proc_id = next_proc_id;
        next_proc_id++;
      end
      if (keep) add_expected(r);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d id %0h", status_o, proc_id_o));
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 16'(status_o), 16'(want.status));
        compare_field("proc_id", 16'(proc_id_o), 16'(want.proc_id));
        compare_field("slice_time", slice_time_o, want.slice_time);
        compare_field("slice_prio", 16'(slice_prio_o), 16'(want.slice_prio));
        compare_field("ends_process", 16'(ends_process_o), 16'(want.ends));
        compare_field("last", 16'(last_o), 16'(want.last));
      end
    end
  end

  task automatic issue_command(logic mode, logic [15:0] et, logic [7:0] pr, bit typed,
                               sched_result_t typed_res);
    start_i     <= 1'b1;
    mode_i      <= mode;
    exec_time_i <= et;
    prio_i      <= pr;
    do @(posedge clk_i); while (busy_o);
    schedule_command(mode, et, pr, !typed);
    if (typed) add_expected(typed_res);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start_i     <= 1'b0;
      mode_i      <= 1'($urandom);
      exec_time_i <= 16'($urandom);
      prio_i      <= 8'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [15:0] q);
    while (busy_o) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 16'($urandom);
    quantum_reg = q;
  endtask

  task automatic run_random(int count, int idle_pct);
    logic        mode;
    logic [15:0] et;
    logic [7:0]  pr;
    int          near;
    repeat (count) begin
      sender_gap(idle_pct);
      mode = ($urandom_range(0, 99) < 10) ? MODE_DRAIN : MODE_INSERT;
      case ($urandom_range(0, 3))
        0: begin
          near = int'(quantum_reg) + int'($urandom_range(0, 2)) - 1;
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          et = 16'(near);
        end
        1: et = 16'($urandom_range(0, 16));
        default: et = 16'($urandom);
      endcase
      pr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      issue_command(mode, et, pr, 1'b0, '0);
    end
  endtask

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    sched_result_t typed_res;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      typed_res         = '0;
      typed_res.status  = DIRECTED_ROWS[i].st;
      typed_res.proc_id = DIRECTED_ROWS[i].id;
      typed_res.last    = 1'b1;
      issue_command(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].exec_time, DIRECTED_ROWS[i].prio,
                    DIRECTED_ROWS[i].typed, typed_res);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_quantum(QUANTA[p]);
      run_random(PHASE_ITEMS, IDLE_PCT[p]);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
